[sv/pca_pkg.sv]
// Shared types and constants for the priority capacity allocator.
`default_nettype none
package pca_pkg;

    localparam int IDX_W = 6;
    localparam int PRI_W = 2;
    localparam int AMT_W = 24;
    localparam int TOT_W = 30;
    localparam int PRD_W = 2 * AMT_W;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_RUN  = 1'b1;

    localparam logic MODE_GREEDY = 1'b0;
    localparam logic MODE_PROP   = 1'b1;

    localparam logic [PRI_W-1:0] TIER_FIRST = 2'd1;
    localparam logic [PRI_W-1:0] TIER_LAST  = 2'd3;

    typedef struct packed {
        logic             op;
        logic [PRI_W-1:0] priority_req;
        logic [AMT_W-1:0] demand;
        logic [AMT_W-1:0] capacity;
    } req_t;

    typedef struct packed {
        logic [IDX_W-1:0] entry_index;
        logic [AMT_W-1:0] allocated;
        logic             last;
    } rsp_t;

    typedef struct packed {
        logic [PRI_W-1:0] prio;
        logic [AMT_W-1:0] demand;
    } entry_t;

endpackage
`default_nettype wire

[sv/pca_tbl.sv]
// Entry table and grant table memories with registered read.
`default_nettype none
module pca_tbl #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic                      clk,
    input  wire logic                      ent_we,
    input  wire logic [AW-1:0]             ent_waddr,
    input  wire pca_pkg::entry_t           ent_wdata,
    input  wire logic                      grt_we,
    input  wire logic [AW-1:0]             grt_waddr,
    input  wire logic [pca_pkg::AMT_W-1:0] grt_wdata,
    input  wire logic [AW-1:0]             rd_addr,
    output pca_pkg::entry_t                ent_rdata,
    output logic [pca_pkg::AMT_W-1:0]      grt_rdata
);
    import pca_pkg::*;

    entry_t           ent_mem [DEPTH];
    logic [AMT_W-1:0] grt_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_mem[ent_waddr] <= ent_wdata;
        end
        ent_rdata <= ent_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (grt_we)
        begin
            grt_mem[grt_waddr] <= grt_wdata;
        end
        grt_rdata <= grt_mem[rd_addr];
    end

endmodule
`default_nettype wire

[sv/pca_div.sv]
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module pca_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [pca_pkg::PRD_W-1:0] dividend,
    input  wire logic [pca_pkg::TOT_W-1:0] divisor,
    output logic                           done,
    output logic [pca_pkg::AMT_W-1:0]      quotient
);
    import pca_pkg::*;

    localparam int CNT_W = $clog2(PRD_W + 1);

    logic [TOT_W-1:0] rem_reg,  rem_next;
    logic [PRD_W-1:0] quo_reg,  quo_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic             done_reg, done_next;
    logic [TOT_W:0]   trial;
    logic [TOT_W:0]   diff;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[PRD_W-1]};
        diff      = trial - {1'b0, divisor};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            quo_next = dividend;
            cnt_next = CNT_W'(PRD_W);
        end
        else if (cnt_reg != '0)
        begin
            if (trial >= {1'b0, divisor})
            begin
                rem_next = diff[TOT_W-1:0];
                quo_next = {quo_reg[PRD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[TOT_W-1:0];
                quo_next = {quo_reg[PRD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg[AMT_W-1:0];

endmodule
`default_nettype wire

[sv/priority_capacity_allocator.sv]
// Priority capacity allocator top level: load, run sequencing and result output.
// Load items are taken one per cycle while idle; a load beyond MAX_ENTRIES is dropped.
// A run item starts a sequence over a non-empty table, which has a single read port:
// greedy mode makes one scan of the table per entry served; proportional mode makes
// a summing scan per tier, then, if the tier has demand, either a fill scan or a share
// walk over every entry, with a multiply and a divide for each entry of the tier
// (the divider yields one bit per cycle). Results then leave one at a time, in load
// order, with last on the final one.
// No new item is taken until the final result of a run has been accepted.
`default_nettype none
module priority_capacity_allocator #(
    parameter int MAX_ENTRIES = 64
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire pca_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output pca_pkg::rsp_t      rsp,
    input  wire logic          mode_we,
    input  wire logic          mode_wdata
);
    import pca_pkg::*;

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_GSCAN  = 11'b00000000010,
        S_PSUM   = 11'b00000000100,
        S_PFILL  = 11'b00000001000,
        S_SHRD   = 11'b00000010000,
        S_SHCHK  = 11'b00000100000,
        S_SHMUL  = 11'b00001000000,
        S_SHDIV  = 11'b00010000000,
        S_EMRD   = 11'b00100000000,
        S_EMCAP  = 11'b01000000000,
        S_EMWAIT = 11'b10000000000
    } state_t;

    state_t                 state_reg, state_next;
    logic                   mode_reg;
    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          scan_reg, scan_next;
    logic                   dv_reg, dv_next;
    logic [AW-1:0]          didx_reg;
    logic [AMT_W-1:0]       rem_reg, rem_next;
    logic [TOT_W-1:0]       total_reg, total_next;
    logic [PRI_W-1:0]       tier_reg, tier_next;
    logic [MAX_ENTRIES-1:0] done_reg, done_next;
    logic                   found_reg, found_next;
    logic [AW-1:0]          bidx_reg, bidx_next;
    logic [PRI_W-1:0]       bpri_reg, bpri_next;
    logic [AMT_W-1:0]       bdem_reg, bdem_next;
    logic [CW-1:0]          served_reg, served_next;
    logic [PRD_W-1:0]       prod_reg, prod_next;
    rsp_t                   rsp_reg, rsp_next;

    logic             ent_we;
    entry_t           ent_wdata;
    logic             grt_we;
    logic [AW-1:0]    grt_waddr;
    logic [AMT_W-1:0] grt_wdata;
    entry_t           ent_rd;
    logic [AMT_W-1:0] grt_rd;
    logic             div_start;
    logic             div_done;
    logic [AMT_W-1:0] div_q;

    logic             in_pass;
    logic             pass_end;
    logic             match;
    logic             scan_last;
    logic [AMT_W-1:0] give;

    pca_tbl #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_tbl (
        .clk       (clk),
        .ent_we    (ent_we),
        .ent_waddr (count_reg[AW-1:0]),
        .ent_wdata (ent_wdata),
        .grt_we    (grt_we),
        .grt_waddr (grt_waddr),
        .grt_wdata (grt_wdata),
        .rd_addr   (scan_reg[AW-1:0]),
        .ent_rdata (ent_rd),
        .grt_rdata (grt_rd)
    );

    pca_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (total_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = (state_reg == S_EMWAIT);
    assign rsp       = rsp_reg;

    always_comb
    begin
        in_pass   = (state_reg == S_GSCAN) || (state_reg == S_PSUM) || (state_reg == S_PFILL);
        pass_end  = in_pass && (scan_reg == count_reg) && !dv_reg;
        match     = (ent_rd.prio == tier_reg);
        scan_last = (scan_reg == count_reg - 1'b1);
        give      = (bdem_reg < rem_reg) ? bdem_reg : rem_reg;

        state_next  = state_reg;
        count_next  = count_reg;
        scan_next   = scan_reg;
        dv_next     = 1'b0;
        rem_next    = rem_reg;
        total_next  = total_reg;
        tier_next   = tier_reg;
        done_next   = done_reg;
        found_next  = found_reg;
        bidx_next   = bidx_reg;
        bpri_next   = bpri_reg;
        bdem_next   = bdem_reg;
        served_next = served_reg;
        prod_next   = prod_reg;
        rsp_next    = rsp_reg;
        ent_we      = 1'b0;
        ent_wdata   = '{prio: req.priority_req, demand: req.demand};
        grt_we      = 1'b0;
        grt_waddr   = didx_reg;
        grt_wdata   = ent_rd.demand;
        div_start   = 1'b0;

        if (in_pass)
        begin
            if (scan_reg < count_reg)
            begin
                scan_next = scan_reg + 1'b1;
            end
            dv_next = (scan_reg < count_reg);
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    if (req.op == OP_LOAD)
                    begin
                        if (count_reg < CW'(MAX_ENTRIES))
                        begin
                            ent_we     = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        rem_next = req.capacity;
                        if (count_reg != '0)
                        begin
                            scan_next   = '0;
                            done_next   = '0;
                            found_next  = 1'b0;
                            served_next = '0;
                            tier_next   = TIER_FIRST;
                            total_next  = '0;
                            state_next  = (mode_reg == MODE_GREEDY) ? S_GSCAN : S_PSUM;
                        end
                    end
                end
            end
            S_GSCAN:
            begin
                if (dv_reg && !done_reg[didx_reg] && (!found_reg || (ent_rd.prio < bpri_reg)
                    || ((ent_rd.prio == bpri_reg) && (ent_rd.demand > bdem_reg))))
                begin
                    found_next = 1'b1;
                    bidx_next  = didx_reg;
                    bpri_next  = ent_rd.prio;
                    bdem_next  = ent_rd.demand;
                end
                if (pass_end)
                begin
                    grt_we              = 1'b1;
                    grt_waddr           = bidx_reg;
                    grt_wdata           = give;
                    done_next[bidx_reg] = 1'b1;
                    rem_next            = rem_reg - give;
                    served_next         = served_reg + 1'b1;
                    found_next          = 1'b0;
                    scan_next           = '0;
                    if (served_reg + 1'b1 == count_reg)
                    begin
                        state_next = S_EMRD;
                    end
                end
            end
            S_PSUM:
            begin
                if (dv_reg && match)
                begin
                    total_next = total_reg + TOT_W'(ent_rd.demand);
                end
                if (pass_end)
                begin
                    scan_next = '0;
                    if (total_reg == '0)
                    begin
                        if (tier_reg == TIER_LAST)
                        begin
                            state_next = S_EMRD;
                        end
                        else
                        begin
                            tier_next = tier_reg + 1'b1;
                        end
                    end
                    else if (TOT_W'(rem_reg) >= total_reg)
                    begin
                        state_next = S_PFILL;
                    end
                    else
                    begin
                        state_next = S_SHRD;
                    end
                end
            end
            S_PFILL:
            begin
                if (dv_reg && match)
                begin
                    grt_we              = 1'b1;
                    done_next[didx_reg] = 1'b1;
                end
                if (pass_end)
                begin
                    rem_next   = rem_reg - total_reg[AMT_W-1:0];
                    scan_next  = '0;
                    total_next = '0;
                    if (tier_reg == TIER_LAST)
                    begin
                        state_next = S_EMRD;
                    end
                    else
                    begin
                        tier_next  = tier_reg + 1'b1;
                        state_next = S_PSUM;
                    end
                end
            end
            S_SHRD:
            begin
                state_next = S_SHCHK;
            end
            S_SHCHK, S_SHDIV:
            begin
                if ((state_reg == S_SHCHK) && match)
                begin
                    prod_next  = PRD_W'(rem_reg) * PRD_W'(ent_rd.demand);
                    state_next = S_SHMUL;
                end
                else if ((state_reg == S_SHCHK) || div_done)
                begin
                    if (state_reg == S_SHDIV)
                    begin
                        grt_we                      = 1'b1;
                        grt_waddr                   = scan_reg[AW-1:0];
                        grt_wdata                   = div_q;
                        done_next[scan_reg[AW-1:0]] = 1'b1;
                    end
                    if (scan_last)
                    begin
                        rem_next   = '0;
                        scan_next  = '0;
                        total_next = '0;
                        if (tier_reg == TIER_LAST)
                        begin
                            state_next = S_EMRD;
                        end
                        else
                        begin
                            tier_next  = tier_reg + 1'b1;
                            state_next = S_PSUM;
                        end
                    end
                    else
                    begin
                        scan_next  = scan_reg + 1'b1;
                        state_next = S_SHRD;
                    end
                end
            end
            S_SHMUL:
            begin
                div_start  = 1'b1;
                state_next = S_SHDIV;
            end
            S_EMRD:
            begin
                state_next = S_EMCAP;
            end
            S_EMCAP:
            begin
                rsp_next.entry_index = IDX_W'(scan_reg[AW-1:0]);
                rsp_next.allocated   = done_reg[scan_reg[AW-1:0]] ? grt_rd : '0;
                rsp_next.last        = scan_last;
                state_next           = S_EMWAIT;
            end
            S_EMWAIT:
            begin
                if (rsp_ready)
                begin
                    if (rsp_reg.last)
                    begin
                        count_next = '0;
                        scan_next  = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        scan_next  = scan_reg + 1'b1;
                        state_next = S_EMRD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            dv_reg    <= 1'b0;
            mode_reg  <= MODE_GREEDY;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            dv_reg    <= dv_next;
            if (mode_we)
            begin
                mode_reg <= mode_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg   <= scan_next;
        didx_reg   <= scan_reg[AW-1:0];
        rem_reg    <= rem_next;
        total_reg  <= total_next;
        tier_reg   <= tier_next;
        done_reg   <= done_next;
        found_reg  <= found_next;
        bidx_reg   <= bidx_next;
        bpri_reg   <= bpri_next;
        bdem_reg   <= bdem_next;
        served_reg <= served_next;
        prod_reg   <= prod_next;
        rsp_reg    <= rsp_next;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_ENTRIES))
        else $error("entry count beyond table size");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_ready && rsp.last) |=> (count_reg == '0) && req_ready)
        else $error("table not emptied after final result");

    a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_SHDIV))
        else $error("divider finished outside share step");

    a_grant_once: assert property (@(posedge clk) disable iff (!rst_n)
        grt_we |-> !done_reg[grt_waddr])
        else $error("entry granted twice in one run");

endmodule
`default_nettype wire

[bench/pca_checker.sv]
// Checker for the priority capacity allocator: predicts grants from accepted items and compares.
`timescale 1ns / 100ps
`default_nettype none
module pca_checker (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    input  wire logic          req_ready,
    input  wire pca_pkg::req_t req,
    input  wire logic          rsp_valid,
    input  wire logic          rsp_ready,
    input  wire pca_pkg::rsp_t rsp,
    input  wire logic          mode_we,
    input  wire logic          mode_wdata,
    output int                 fail_count,
    output int                 grants_pending
);
    import pca_pkg::*;

    localparam int DEPTH = 64;

    logic [PRI_W-1:0] tbl_prio [DEPTH];
    logic [AMT_W-1:0] tbl_demand [DEPTH];
    int               tbl_count;
    logic             cur_mode;
    rsp_t             grant_q [$];

    assign grants_pending = grant_q.size();

    task automatic compute_grants(input logic [AMT_W-1:0] cap);
        logic [AMT_W-1:0] grant [DEPTH];
        int               order [DEPTH];
        logic [AMT_W-1:0] left;
        logic [TOT_W-1:0] total;
        logic [PRD_W-1:0] prod;
        int               key, j, e;
        rsp_t             r;
        left = cap;
        for (int i = 0; i < tbl_count; i++)
        begin
            grant[i] = '0;
            order[i] = i;
        end
        if (cur_mode == MODE_GREEDY)
        begin
            for (int i = 1; i < tbl_count; i++)
            begin
                key = order[i];
                j = i;
                while (j > 0 && (tbl_prio[key] < tbl_prio[order[j-1]] ||
                       (tbl_prio[key] == tbl_prio[order[j-1]] &&
                        tbl_demand[key] > tbl_demand[order[j-1]])))
                begin
                    order[j] = order[j-1];
                    j--;
                end
                order[j] = key;
            end
            for (int i = 0; i < tbl_count; i++)
            begin
                e = order[i];
                grant[e] = (tbl_demand[e] > left) ? left : tbl_demand[e];
                left = left - grant[e];
            end
        end
        else
        begin
            for (int t = TIER_FIRST; t <= TIER_LAST; t++)
            begin
                total = '0;
                for (int i = 0; i < tbl_count; i++)
                    if (tbl_prio[i] == t)
                        total = total + tbl_demand[i];
                if (total != 0)
                begin
                    if (total <= left)
                    begin
                        for (int i = 0; i < tbl_count; i++)
                            if (tbl_prio[i] == t)
                                grant[i] = tbl_demand[i];
                        left = left - total[AMT_W-1:0];
                    end
                    else
                    begin
                        for (int i = 0; i < tbl_count; i++)
                            if (tbl_prio[i] == t)
                            begin
                                prod = left * tbl_demand[i];
                                grant[i] = AMT_W'(prod / total);
                            end
                        left = '0;
                    end
                end
            end
        end
        for (int i = 0; i < tbl_count; i++)
        begin
            r.entry_index = IDX_W'(i);
            r.allocated   = grant[i];
            r.last        = (i + 1 == tbl_count);
            grant_q.push_back(r);
        end
        tbl_count = 0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t exp_r;
        if (!rst_n)
        begin
            tbl_count  = 0;
            cur_mode   = MODE_GREEDY;
            fail_count = 0;
            grant_q.delete();
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                if (req.op == OP_LOAD)
                begin
                    if (tbl_count < DEPTH)
                    begin
                        tbl_prio[tbl_count]   = req.priority_req;
                        tbl_demand[tbl_count] = req.demand;
                        tbl_count++;
                    end
                end
                else
                    compute_grants(req.capacity);
            end
            if (mode_we)
                cur_mode = mode_wdata;
            if (rsp_valid && rsp_ready)
            begin
                if (grant_q.size() == 0)
                begin
                    $display("%0t: unexpected result %p", $time, rsp);
                    fail_count++;
                end
                else
                begin
                    exp_r = grant_q.pop_front();
                    if (exp_r !== rsp)
                    begin
                        $display("%0t: mismatch expected %p actual %p", $time, exp_r, rsp);
                        fail_count++;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

[bench/tb_top.sv]
// Testbench top for the priority capacity allocator: stimulus, idling and verdict.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import pca_pkg::*;

    localparam longint CYCLE_LIMIT = 4000000;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   req_valid = 1'b0;
    logic   req_ready;
    req_t   req = '0;
    logic   rsp_valid;
    logic   rsp_ready = 1'b0;
    rsp_t   rsp;
    logic   mode_we = 1'b0;
    logic   mode_wdata = 1'b0;
    int     fail_count;
    int     grants_pending;
    longint cycles = 0;
    bit     hold_off = 1'b0;

    always #10 clk = ~clk;

    priority_capacity_allocator #(.MAX_ENTRIES(64)) dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
        .mode_we(mode_we), .mode_wdata(mode_wdata)
    );

    pca_checker chk (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
        .mode_we(mode_we), .mode_wdata(mode_wdata),
        .fail_count(fail_count), .grants_pending(grants_pending)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // Receiver: random gaps, and a long hold-off on request.
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
            gap = $urandom_range(0, 6);
            if ($urandom_range(0, 3) == 0)
                gap = 0;
            if (gap > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (gap - 1) @(posedge clk);
                @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do @(posedge clk); while (!(rsp_valid && rsp_ready));
            rsp_ready <= 1'b0;
            #0;
        end
    end

    task automatic send(input logic op, input logic [PRI_W-1:0] pri,
                        input logic [AMT_W-1:0] dem, input logic [AMT_W-1:0] cap);
        int gap;
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req.op <= op;
        req.priority_req <= pri;
        req.demand <= dem;
        req.capacity <= cap;
        do @(posedge clk); while (!req_ready);
    endtask

    task automatic drain_and_set_mode(input logic m);
        req_valid <= 1'b0;
        @(posedge clk);
        while (grants_pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        mode_we <= 1'b1;
        mode_wdata <= m;
        @(posedge clk);
        mode_we <= 1'b0;
    endtask

    function automatic logic [AMT_W-1:0] rand_amt();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return '1;
            2: return AMT_W'($urandom_range(0, 255));
            default: return AMT_W'($urandom);
        endcase
    endfunction

    task automatic random_batch(input int n, input bit mixed_pri);
        logic [PRI_W-1:0] p;
        for (int i = 0; i < n; i++)
        begin
            p = mixed_pri ? PRI_W'($urandom_range(0, 3)) : PRI_W'($urandom_range(1, 3));
            send(OP_LOAD, p, rand_amt(), AMT_W'($urandom));
        end
        send(OP_RUN, PRI_W'($urandom), AMT_W'($urandom), rand_amt());
    endtask

    initial
    begin
        int n;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty run, extremes, priority zero, zero tier.
        send(OP_RUN, '0, '0, '1);
        send(OP_LOAD, 2'd1, '1, '0);
        send(OP_LOAD, 2'd3, '0, '1);
        send(OP_LOAD, 2'd0, 24'd100, '0);
        send(OP_LOAD, 2'd2, 24'd100, '0);
        send(OP_LOAD, 2'd2, 24'd100, '0);
        send(OP_RUN, '1, '1, 24'h000300);
        send(OP_LOAD, 2'd1, 24'd5, '0);
        send(OP_RUN, '0, '0, '0);
        drain_and_set_mode(MODE_PROP);
        send(OP_LOAD, 2'd1, '0, '0);
        send(OP_LOAD, 2'd2, 24'd300, '0);
        send(OP_LOAD, 2'd2, 24'd700, '0);
        send(OP_LOAD, 2'd0, 24'd50, '0);
        send(OP_LOAD, 2'd3, 24'd10, '0);
        send(OP_RUN, '0, '0, 24'd999);
        send(OP_LOAD, 2'd1, '1, '0);
        send(OP_LOAD, 2'd1, '1, '0);
        send(OP_RUN, '0, '0, '1);
        send(OP_LOAD, 2'd3, 24'd4, '0);
        send(OP_RUN, '0, '0, '1);

        // Full table with a long receiver hold-off; extra loads dropped.
        drain_and_set_mode(MODE_GREEDY);
        for (int i = 0; i < 66; i++)
            send(OP_LOAD, PRI_W'($urandom_range(1, 3)), AMT_W'($urandom_range(0, 4095)), '0);
        hold_off = 1'b1;
        send(OP_RUN, '0, '0, AMT_W'($urandom_range(0, 60000)));
        send(OP_LOAD, 2'd1, 24'd1, '0);
        send(OP_LOAD, 2'd2, 24'd2, '0);
        send(OP_RUN, '0, '0, 24'd2);

        // Random: small batches in randomly chosen modes, then a batch of 24 in proportional mode.
        for (int b = 0; b < 12; b++)
        begin
            if (b % 4 == 0)
                drain_and_set_mode(logic'($urandom_range(0, 1)));
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(1, 6);
            random_batch(n, $urandom_range(0, 4) == 0);
        end
        drain_and_set_mode(MODE_PROP);
        random_batch(24, 1'b0);

        req_valid <= 1'b0;
        @(posedge clk);
        while (grants_pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end
endmodule
`default_nettype wire

[sim.f]
sv/pca_pkg.sv
sv/pca_tbl.sv
sv/pca_div.sv
sv/priority_capacity_allocator.sv
bench/pca_checker.sv
bench/tb_top.sv
